// File: src/cpe_pkg.sv
// ----------------------------------------------------------------------------
// cpe_pkg
// shared types, register indexes, microcode fields and the control store
// ----------------------------------------------------------------------------
package cpe_pkg;

    typedef logic signed [31:0] t_q16;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;
    localparam int PC_W       = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP       = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_FROM_VEL    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_FROM_ANGLE  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_FROM_VEL   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_FROM_ANGLE = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_FORCE_GAIN  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_FORCE_GAIN = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_POSE    = 4'd7;

    localparam logic [15:0] TIME_STEP_RESET = 16'd655;

    typedef struct packed {
        logic [15:0] time_step;
        t_q16        vel_from_vel;
        t_q16        vel_from_angle;
        t_q16        rate_from_vel;
        t_q16        rate_from_angle;
        t_q16        vel_force_gain;
        t_q16        rate_force_gain;
    } t_cfg;

    // multiplier operand a
    localparam logic [2:0] A_VFV = 3'd0;
    localparam logic [2:0] A_VFA = 3'd1;
    localparam logic [2:0] A_VFG = 3'd2;
    localparam logic [2:0] A_RFV = 3'd3;
    localparam logic [2:0] A_RFA = 3'd4;
    localparam logic [2:0] A_RFG = 3'd5;
    localparam logic [2:0] A_TS  = 3'd6;

    // multiplier operand b
    localparam logic [2:0] B_VEL   = 3'd0;
    localparam logic [2:0] B_ANG   = 3'd1;
    localparam logic [2:0] B_FRC   = 3'd2;
    localparam logic [2:0] B_RATE  = 3'd3;
    localparam logic [2:0] B_DVEL  = 3'd4;
    localparam logic [2:0] B_DRATE = 3'd5;

    // operation on the registered product of the previous step
    localparam logic [3:0] OP_NOP       = 4'd0;
    localparam logic [3:0] OP_LOAD      = 4'd1;
    localparam logic [3:0] OP_ADD       = 4'd2;
    localparam logic [3:0] OP_ADD_DVEL  = 4'd3;
    localparam logic [3:0] OP_ADD_DRATE = 4'd4;
    localparam logic [3:0] OP_EUL_POS   = 4'd5;
    localparam logic [3:0] OP_EUL_VEL   = 4'd6;
    localparam logic [3:0] OP_EUL_ANG   = 4'd7;
    localparam logic [3:0] OP_EUL_RATE  = 4'd8;

    localparam logic [PC_W-1:0] PC_LAST = 4'd10;

    typedef struct packed {
        logic [2:0]      a_sel;
        logic [2:0]      b_sel;
        logic            mul_en;
        logic [3:0]      op;
        logic            jz;     // jump when time step is zero
        logic [PC_W-1:0] tgt;
        logic            last;
    } t_uword;

    typedef struct packed {
        logic   active;
        t_uword uw;
    } t_ctl;

    function automatic t_q16 sat32(input logic signed [49:0] v);
        t_q16 r;
        if (v > 50'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -50'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // control store
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '{a_sel: A_VFV, b_sel: B_VEL, mul_en: 1'b0, op: OP_NOP,
              jz: 1'b0, tgt: '0, last: 1'b0};
        case (pc)
            4'd0: begin
                w.a_sel = A_VFV; w.b_sel = B_VEL;  w.mul_en = 1'b1;
            end
            4'd1: begin
                w.a_sel = A_VFA; w.b_sel = B_ANG;  w.mul_en = 1'b1; w.op = OP_LOAD;
            end
            4'd2: begin
                w.a_sel = A_VFG; w.b_sel = B_FRC;  w.mul_en = 1'b1; w.op = OP_ADD;
            end
            4'd3: begin
                w.a_sel = A_RFV; w.b_sel = B_VEL;  w.mul_en = 1'b1; w.op = OP_ADD_DVEL;
            end
            4'd4: begin
                w.a_sel = A_RFA; w.b_sel = B_ANG;  w.mul_en = 1'b1; w.op = OP_LOAD;
            end
            4'd5: begin
                w.a_sel = A_RFG; w.b_sel = B_FRC;  w.mul_en = 1'b1; w.op = OP_ADD;
            end
            4'd6: begin
                w.a_sel = A_TS;  w.b_sel = B_VEL;  w.mul_en = 1'b1; w.op = OP_ADD_DRATE;
                w.jz = 1'b1;     w.tgt = PC_LAST;
            end
            4'd7: begin
                w.a_sel = A_TS;  w.b_sel = B_DVEL; w.mul_en = 1'b1; w.op = OP_EUL_POS;
            end
            4'd8: begin
                w.a_sel = A_TS;  w.b_sel = B_RATE; w.mul_en = 1'b1; w.op = OP_EUL_VEL;
            end
            4'd9: begin
                w.a_sel = A_TS;  w.b_sel = B_DRATE; w.mul_en = 1'b1; w.op = OP_EUL_ANG;
            end
            4'd10: begin
                w.op = OP_EUL_RATE; w.last = 1'b1;
            end
            default: begin
                w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

// File: src/cpe_seq.sv
// ----------------------------------------------------------------------------
// cpe_seq
// step counter and control store walk, with a jump on zero time step
// ----------------------------------------------------------------------------
module cpe_seq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_hold,
    input  logic          i_ts_zero,
    output logic          o_busy,
    output cpe_pkg::t_ctl o_ctl
);
    import cpe_pkg::*;

    logic            r_busy, n_busy;
    logic [PC_W-1:0] r_pc, n_pc;
    t_uword          uw;

    assign uw = ucode(r_pc);

    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        if (!r_busy) begin
            if (i_start) begin
                n_busy = 1'b1;
                n_pc   = '0;
            end
        end else if (!i_hold) begin
            if (uw.last) begin
                n_busy = 1'b0;
            end else if (uw.jz && i_ts_zero) begin
                n_pc = uw.tgt;
            end else begin
                n_pc = r_pc + PC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= '0;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

    assign o_busy       = r_busy;
    assign o_ctl.active = r_busy && !i_hold;
    assign o_ctl.uw     = uw;

endmodule

// File: src/cpe_dp.sv
// ----------------------------------------------------------------------------
// cpe_dp
// shared multiplier, accumulator and the four state registers
// ----------------------------------------------------------------------------
module cpe_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cpe_pkg::t_cfg i_cfg,
    input  cpe_pkg::t_ctl i_ctl,
    input  logic          i_load_force,
    input  cpe_pkg::t_q16 i_force,
    input  logic          i_pose_load,
    input  logic [63:0]   i_pose,
    output cpe_pkg::t_q16 o_position,
    output cpe_pkg::t_q16 o_angle
);
    import cpe_pkg::*;

    t_q16 r_pos, r_vel, r_ang, r_rate;
    t_q16 r_force, r_dvel, r_drate;
    logic signed [64:0] r_prod;
    logic signed [49:0] r_acc;

    logic signed [32:0] mul_a;
    t_q16               mul_b;
    logic signed [48:0] term;
    logic signed [49:0] acc_sum;
    t_q16               eul_old;
    logic signed [49:0] eul_sum;
    t_q16               eul_new;

    always_comb begin
        case (i_ctl.uw.a_sel)
            A_VFV:   mul_a = {i_cfg.vel_from_vel[31], i_cfg.vel_from_vel};
            A_VFA:   mul_a = {i_cfg.vel_from_angle[31], i_cfg.vel_from_angle};
            A_VFG:   mul_a = {i_cfg.vel_force_gain[31], i_cfg.vel_force_gain};
            A_RFV:   mul_a = {i_cfg.rate_from_vel[31], i_cfg.rate_from_vel};
            A_RFA:   mul_a = {i_cfg.rate_from_angle[31], i_cfg.rate_from_angle};
            A_RFG:   mul_a = {i_cfg.rate_force_gain[31], i_cfg.rate_force_gain};
            A_TS:    mul_a = {17'd0, i_cfg.time_step};
            default: mul_a = '0;
        endcase
        case (i_ctl.uw.b_sel)
            B_VEL:   mul_b = r_vel;
            B_ANG:   mul_b = r_ang;
            B_FRC:   mul_b = r_force;
            B_RATE:  mul_b = r_rate;
            B_DVEL:  mul_b = r_dvel;
            B_DRATE: mul_b = r_drate;
            default: mul_b = '0;
        endcase
    end

    // product floored to q16.16 scale
    assign term    = r_prod[64:16];
    assign acc_sum = r_acc + 50'(term);

    always_comb begin
        case (i_ctl.uw.op)
            OP_EUL_POS:  eul_old = r_pos;
            OP_EUL_VEL:  eul_old = r_vel;
            OP_EUL_ANG:  eul_old = r_ang;
            OP_EUL_RATE: eul_old = r_rate;
            default:     eul_old = '0;
        endcase
    end

    assign eul_sum = 50'(eul_old) + 50'(term);
    assign eul_new = sat32(eul_sum);

    always_ff @(posedge i_clk) begin
        if (i_ctl.active && i_ctl.uw.mul_en) begin
            r_prod <= 65'(mul_a) * 65'(mul_b);
        end
        if (i_load_force) begin
            r_force <= i_force;
        end
        if (i_ctl.active) begin
            case (i_ctl.uw.op)
                OP_LOAD:      r_acc   <= 50'(term);
                OP_ADD:       r_acc   <= acc_sum;
                OP_ADD_DVEL:  r_dvel  <= sat32(acc_sum);
                OP_ADD_DRATE: r_drate <= sat32(acc_sum);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_vel  <= '0;
            r_ang  <= '0;
            r_rate <= '0;
        end else if (i_pose_load) begin
            r_pos  <= i_pose[31:0];
            r_ang  <= i_pose[63:32];
            r_vel  <= '0;
            r_rate <= '0;
        end else if (i_ctl.active) begin
            case (i_ctl.uw.op)
                OP_EUL_POS:  r_pos  <= eul_new;
                OP_EUL_VEL:  r_vel  <= eul_new;
                OP_EUL_ANG:  r_ang  <= eul_new;
                OP_EUL_RATE: r_rate <= eul_new;
                default: begin
                end
            endcase
        end
    end

    assign o_position = r_pos;
    assign o_angle    = r_ang;

endmodule

// File: src/cart_pendulum_euler_step_top.sv
// ----------------------------------------------------------------------------
// cart_pendulum_euler_step_top
// linearised cart-pole model advanced by one forward euler step per force
// ----------------------------------------------------------------------------
//
// channel   dir   handshake                       payload
// s_axis    in    s_axis_tvalid / s_axis_tready   tdata[31:0] cart_force
// m_axis    out   m_axis_tvalid / m_axis_tready   tdata[31:0] cart_position,
//                                                 tdata[63:32] pendulum_angle
// cfg       in    i_cfg_we (no wait)              i_cfg_idx, i_cfg_data
//
// a force is accepted while the sequencer is idle and then runs through
// eleven microcode steps (a stalled output can hold the last one), each issuing
// at most one product on the single 33x32 multiplier (ten products, one at a time)
// a zero time step jumps past the three remaining euler products
// synchronous active-low reset loads the state from the reset pose (all zero)
// the result sits in an output register; a stalled output only holds the
// final step, the next force is accepted once the sequencer is idle
//
module cart_pendulum_euler_step_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // force input
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [31:0]                   s_axis_tdata,   // [31:0] cart_force
    // result output
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [63:0]                   m_axis_tdata,   // [31:0] cart_position,
                                                          // [63:32] pendulum_angle
    // configuration writes
    input  logic                          i_cfg_we,
    input  logic [cpe_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cpe_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import cpe_pkg::*;

    t_cfg        r_cfg;
    logic        r_out_valid;
    logic [63:0] r_out_data;

    logic        busy;
    logic        start;
    logic        hold;
    logic        pose_load;
    t_ctl        ctl;
    t_uword      cur_uw;
    t_q16        position;
    t_q16        angle;

    // force accepted only while the sequencer is idle
    assign s_axis_tready = !busy;
    assign start         = s_axis_tvalid && !busy;

    // the final step waits while the previous result is still unclaimed
    assign cur_uw = ctl.uw;
    assign hold   = cur_uw.last && r_out_valid && !m_axis_tready;

    // a pose write reloads the state at once
    assign pose_load = i_cfg_we && (i_cfg_idx == REG_INITIAL_POSE);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.time_step       <= TIME_STEP_RESET;
            r_cfg.vel_from_vel    <= '0;
            r_cfg.vel_from_angle  <= '0;
            r_cfg.rate_from_vel   <= '0;
            r_cfg.rate_from_angle <= '0;
            r_cfg.vel_force_gain  <= '0;
            r_cfg.rate_force_gain <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TIME_STEP:       r_cfg.time_step       <= i_cfg_data[15:0];
                REG_VEL_FROM_VEL:    r_cfg.vel_from_vel    <= i_cfg_data[31:0];
                REG_VEL_FROM_ANGLE:  r_cfg.vel_from_angle  <= i_cfg_data[31:0];
                REG_RATE_FROM_VEL:   r_cfg.rate_from_vel   <= i_cfg_data[31:0];
                REG_RATE_FROM_ANGLE: r_cfg.rate_from_angle <= i_cfg_data[31:0];
                REG_VEL_FORCE_GAIN:  r_cfg.vel_force_gain  <= i_cfg_data[31:0];
                REG_RATE_FORCE_GAIN: r_cfg.rate_force_gain <= i_cfg_data[31:0];
                default: begin
                    // pose goes straight to the state; unused indexes dropped
                end
            endcase
        end
    end

    // step counter and control store
    cpe_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_hold    (hold),
        .i_ts_zero (r_cfg.time_step == 16'd0),
        .o_busy    (busy),
        .o_ctl     (ctl)
    );

    // multiplier, accumulator and state
    cpe_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_ctl        (ctl),
        .i_load_force (start),
        .i_force      (s_axis_tdata),
        .i_pose_load  (pose_load),
        .i_pose       (i_cfg_data),
        .o_position   (position),
        .o_angle      (angle)
    );

    // output register; position and angle are final by the last step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.active && cur_uw.last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.active && cur_uw.last) begin
            r_out_data <= {angle, position};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// File: bench/tb_cart_pendulum_euler_step_top.sv
// ----------------------------------------------------------------------------
// tb_cart_pendulum_euler_step_top
// self-checking bench for the cart-pole euler step block
//
// force transfers go in on the slave stream, and an in-bench model of the
// linearised cart-pole advances its own copy of the state for each accepted
// force. every pose on the master stream is checked field by field against
// the oldest predicted pose. a directed part covers reset defaults, extreme
// forces, ignored register indexes, a zero time step, pose reload and
// saturation; random phases then rewrite the registers while idle and push
// bursts of forces with random gaps and output stalls
// ----------------------------------------------------------------------------
module tb_cart_pendulum_euler_step_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cpe_pkg::*;

    localparam int     CLK_HALF      = 10;
    localparam int     RESET_CYCLES  = 12;
    localparam int     RANDOM_PUSHES = 1450;
    // margin for the output register and the sequencer to drain
    localparam int     SETTLE_CYCLES = 24;
    localparam longint Q16_MAX       = 64'sd2147483647;
    localparam longint Q16_MIN       = -64'sd2147483648;

    // ------------------------------------------------------------------------
    // block ports, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata  = '0;   // [31:0] cart_force
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [63:0]           m_axis_tdata;         // [31:0] cart_position, [63:32] pendulum_angle
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    cart_pendulum_euler_step_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // cart-pole model: its own registers and state
    // ------------------------------------------------------------------------
    logic [15:0] step_size = TIME_STEP_RESET;
    t_q16        k_vel_vel  = '0;
    t_q16        k_vel_ang  = '0;
    t_q16        k_rate_vel = '0;
    t_q16        k_rate_ang = '0;
    t_q16        k_vel_push = '0;
    t_q16        k_rate_push = '0;
    t_q16        cart_pos   = '0;
    t_q16        cart_vel   = '0;
    t_q16        pend_ang   = '0;
    t_q16        pend_rate  = '0;

    // bench bookkeeping
    t_q16        pending_pushes[$];   // forces not yet offered
    logic [63:0] expected_poses[$];   // {angle, position} per accepted force
    logic [63:0] want_pose;
    logic        burst_mode   = 1'b0; // no idling on either side
    logic        force_taken  = 1'b0; // set at the edge a force transfer happens
    logic        pose_taken   = 1'b0; // set at the edge a result transfer happens
    int          push_gap     = 0;
    int          hold_cycles  = 0;
    int          mismatches   = 0;
    int          forces_sent  = 0;
    int          poses_checked = 0;
    int          cfg_writes   = 0;
    int          phases       = 0;

    // q16.16 times q16.16, floor back to q16.16 scale (exact, up to 47 bits)
    function automatic longint scaled_product(input t_q16 a, input t_q16 b);
        return (longint'(a) * longint'(b)) >>> 16;
    endfunction

    function automatic t_q16 clamp_q16(input longint v);
        t_q16 r;
        if (v > Q16_MAX) begin
            r = 32'sh7fffffff;
        end else if (v < Q16_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = t_q16'(v);
        end
        return r;
    endfunction

    // old + floor(step * slope / 2^16), saturated
    function automatic t_q16 euler_update(input t_q16 old, input t_q16 slope);
        longint inc;
        inc = (longint'({48'd0, step_size}) * longint'(slope)) >>> 16;
        return clamp_q16(longint'(old) + inc);
    endfunction

    // one tick of the linearised cart-pole, returns {angle, position}
    function automatic logic [63:0] advance_cart(input t_q16 push);
        t_q16 dvel;
        t_q16 drate;
        t_q16 npos;
        t_q16 nvel;
        t_q16 nang;
        t_q16 nrate;
        dvel  = clamp_q16(scaled_product(k_vel_vel, cart_vel) +
                          scaled_product(k_vel_ang, pend_ang) +
                          scaled_product(k_vel_push, push));
        drate = clamp_q16(scaled_product(k_rate_vel, cart_vel) +
                          scaled_product(k_rate_ang, pend_ang) +
                          scaled_product(k_rate_push, push));
        npos  = euler_update(cart_pos, cart_vel);
        nvel  = euler_update(cart_vel, dvel);
        nang  = euler_update(pend_ang, pend_rate);
        nrate = euler_update(pend_rate, drate);
        cart_pos  = npos;
        cart_vel  = nvel;
        pend_ang  = nang;
        pend_rate = nrate;
        return {pend_ang, cart_pos};
    endfunction

    // register write, only called while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_TIME_STEP:       step_size   = data[15:0];
            REG_VEL_FROM_VEL:    k_vel_vel   = data[31:0];
            REG_VEL_FROM_ANGLE:  k_vel_ang   = data[31:0];
            REG_RATE_FROM_VEL:   k_rate_vel  = data[31:0];
            REG_RATE_FROM_ANGLE: k_rate_ang  = data[31:0];
            REG_VEL_FORCE_GAIN:  k_vel_push  = data[31:0];
            REG_RATE_FORCE_GAIN: k_rate_push = data[31:0];
            REG_INITIAL_POSE: begin
                // pose reload clears both rates
                cart_pos  = data[31:0];
                pend_ang  = data[63:32];
                cart_vel  = '0;
                pend_rate = '0;
            end
            default: ;   // indexes past the list are dropped
        endcase
        cfg_writes++;
    endtask

    // wait until every force went in and every pose came back; sampled at
    // the rising edge so the driver's falling-edge updates have settled
    task automatic wait_idle();
        do begin
            @(posedge i_clk);
        end while (pending_pushes.size() != 0 || s_axis_tvalid ||
                   expected_poses.size() != 0);
        repeat (3) @(negedge i_clk);
    endtask

    function automatic t_q16 pick_coef();
        t_q16 r;
        case ($urandom_range(0, 9))
            0:       r = 32'sh7fffffff;
            1:       r = 32'sh80000000;
            2:       r = '0;
            3:       r = $urandom();
            // within +-4.0 keeps the state off the rails for a while
            default: r = t_q16'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] pick_step();
        logic [15:0] r;
        case ($urandom_range(0, 7))
            0:       r = 16'd0;
            1:       r = 16'hffff;
            2:       r = TIME_STEP_RESET;
            3:       r = $urandom_range(0, 65535);
            default: r = $urandom_range(1, 3000);
        endcase
        return r;
    endfunction

    function automatic t_q16 pick_push();
        t_q16 r;
        case ($urandom_range(0, 9))
            0:       r = 32'sh7fffffff;
            1:       r = 32'sh80000000;
            2:       r = '0;
            3, 4:    r = $urandom();
            default: r = t_q16'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] pick_pose();
        logic [63:0] r;
        case ($urandom_range(0, 7))
            0:       r = {32'h8000_0000, 32'h7fff_ffff};
            1, 2:    r = {$urandom(), $urandom()};
            default: r = {32'($urandom_range(0, 32'h0002_0000)) - 32'h0001_0000,
                          32'($urandom_range(0, 32'h0002_0000)) - 32'h0001_0000};
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // force driver: offers the next pending force after a random gap
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && !force_taken) begin
                // hold the offered force until its transfer
            end else if (push_gap > 0) begin
                push_gap = push_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_pushes.size() > 0) begin
                s_axis_tdata  <= pending_pushes.pop_front();
                s_axis_tvalid <= 1'b1;
                push_gap = burst_mode ? 0 : $urandom_range(0, 9);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
            force_taken = 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // result sink: stalls each pose for a random number of cycles
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (pose_taken) begin
            hold_cycles = burst_mode ? 0 : $urandom_range(0, 9);
            pose_taken  = 1'b0;
        end
        if (hold_cycles > 0) begin
            // the stall only counts down while a pose is waiting
            if (m_axis_tvalid) begin
                hold_cycles = hold_cycles - 1;
            end
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: predicts on force transfers, checks on result transfers
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                pose_taken = 1'b1;
                poses_checked++;
                if (expected_poses.size() == 0) begin
                    $error("pose transfer with none expected: cart_position %0d pendulum_angle %0d",
                           $signed(m_axis_tdata[31:0]), $signed(m_axis_tdata[63:32]));
                    mismatches++;
                end else begin
                    want_pose = expected_poses.pop_front();
                    if (m_axis_tdata[31:0] !== want_pose[31:0]) begin
                        $error("cart_position: expected %0d, got %0d",
                               $signed(want_pose[31:0]), $signed(m_axis_tdata[31:0]));
                        mismatches++;
                    end
                    if (m_axis_tdata[63:32] !== want_pose[63:32]) begin
                        $error("pendulum_angle: expected %0d, got %0d",
                               $signed(want_pose[63:32]), $signed(m_axis_tdata[63:32]));
                        mismatches++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                force_taken = 1'b1;
                forces_sent++;
                expected_poses.push_back(advance_cart(s_axis_tdata));
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus sequence
    // ------------------------------------------------------------------------
    initial begin
        int random_total;
        int phase_len;
        random_total = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: zero coefficients keep the pose at zero
        pending_pushes.push_back(32'sh7fffffff);
        pending_pushes.push_back(32'sh80000000);
        wait_idle();

        // every register once with plausible values, 0.1 s step
        write_reg(REG_TIME_STEP,       64'd6554);
        write_reg(REG_VEL_FROM_VEL,    64'(32'shffff_8000));   // -0.5
        write_reg(REG_VEL_FROM_ANGLE,  64'(32'sh0002_0000));   // 2.0
        write_reg(REG_RATE_FROM_VEL,   64'(32'sh0000_4000));   // 0.25
        write_reg(REG_RATE_FROM_ANGLE, 64'(32'sh0014_0000));   // 20.0, unstable pole
        write_reg(REG_VEL_FORCE_GAIN,  64'(32'sh0001_0000));   // 1.0
        write_reg(REG_RATE_FORCE_GAIN, 64'(32'shfffe_8000));   // -1.5
        write_reg(REG_INITIAL_POSE,    {32'h0000_199a, 32'hffff_0000});
        pending_pushes.push_back(32'sh0000_0000);
        pending_pushes.push_back(32'sh0000_0001);
        pending_pushes.push_back(32'shffff_ffff);
        pending_pushes.push_back(32'sh0001_0000);
        pending_pushes.push_back(32'sh7fff_ffff);
        pending_pushes.push_back(32'sh8000_0000);
        pending_pushes.push_back(32'sh5555_5555);
        pending_pushes.push_back(32'shaaaa_aaaa);
        wait_idle();

        // indexes past the register list must change nothing
        write_reg(4'd8,  {$urandom(), $urandom()});
        write_reg(4'd15, {$urandom(), $urandom()});
        pending_pushes.push_back(32'sh0000_8000);
        pending_pushes.push_back(32'shffff_8000);
        wait_idle();

        // zero step: the pose repeats and the state stays frozen
        write_reg(REG_TIME_STEP, 64'd0);
        pending_pushes.push_back(32'sh7fff_ffff);
        pending_pushes.push_back(32'sh8000_0000);
        pending_pushes.push_back(32'sh1234_5678);
        wait_idle();

        // full-scale everything to drive the rate sums and state into saturation
        write_reg(REG_TIME_STEP,       64'hffff);
        write_reg(REG_VEL_FROM_VEL,    64'(32'sh7fff_ffff));
        write_reg(REG_VEL_FROM_ANGLE,  64'(32'sh8000_0000));
        write_reg(REG_RATE_FROM_VEL,   64'(32'sh8000_0000));
        write_reg(REG_RATE_FROM_ANGLE, 64'(32'sh7fff_ffff));
        write_reg(REG_VEL_FORCE_GAIN,  64'(32'sh7fff_ffff));
        write_reg(REG_RATE_FORCE_GAIN, 64'(32'sh8000_0000));
        write_reg(REG_INITIAL_POSE,    {32'h8000_0000, 32'h7fff_ffff});
        pending_pushes.push_back(32'sh7fff_ffff);
        pending_pushes.push_back(32'sh7fff_ffff);
        pending_pushes.push_back(32'sh8000_0000);
        pending_pushes.push_back(32'sh8000_0000);
        pending_pushes.push_back(32'sh7fff_ffff);
        pending_pushes.push_back(32'sh0000_0000);
        wait_idle();

        // random phases: fresh settings while idle, then a burst of forces
        while (random_total < RANDOM_PUSHES) begin
            burst_mode = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 2) == 0) write_reg(REG_TIME_STEP, 64'(pick_step()));
            if ($urandom_range(0, 2) == 0) write_reg(REG_VEL_FROM_VEL, 64'(pick_coef()));
            if ($urandom_range(0, 2) == 0) write_reg(REG_VEL_FROM_ANGLE, 64'(pick_coef()));
            if ($urandom_range(0, 2) == 0) write_reg(REG_RATE_FROM_VEL, 64'(pick_coef()));
            if ($urandom_range(0, 2) == 0) write_reg(REG_RATE_FROM_ANGLE, 64'(pick_coef()));
            if ($urandom_range(0, 2) == 0) write_reg(REG_VEL_FORCE_GAIN, 64'(pick_coef()));
            if ($urandom_range(0, 2) == 0) write_reg(REG_RATE_FORCE_GAIN, 64'(pick_coef()));
            // frequent reloads pull the state back from the rails
            if ($urandom_range(0, 1) == 0) write_reg(REG_INITIAL_POSE, pick_pose());
            if ($urandom_range(0, 7) == 0) begin
                write_reg(CFG_IDX_W'($urandom_range(8, 15)), {$urandom(), $urandom()});
            end
            phase_len = $urandom_range(10, 60);
            repeat (phase_len) pending_pushes.push_back(pick_push());
            random_total += phase_len;
            phases++;
            wait_idle();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("checked %0d poses against %0d force transfers in %0d random phases",
                 poses_checked, forces_sent, phases);
        $display("%0d register writes: zero and full-scale steps, pose reloads, dropped indexes",
                 cfg_writes);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // watchdog, far above the slowest legal run
    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
